### sv/rbu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_pkg
// Shared types and constants of the raw10 Bayer unpacker: packing modes,
// configuration register indexes, group sizes and the inter-module structs.
// ----------------------------------------------------------------------------
package rbu_pkg;

    localparam int DEF_MAX_WIDTH  = 8192;
    localparam int DEF_MAX_HEIGHT = 8192;

    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 16;
    localparam int PIX10_W    = 10;
    localparam int NPIX_MAX   = 6;
    localparam int CNT_W      = 3;
    localparam int GRP_BYTES  = 8;
    localparam int LANE_W     = 3;
    localparam int GS_W       = 4;
    localparam int LINE_W     = 14;
    localparam int HGT_W      = 14;
    localparam int RSTR_W     = 15;
    localparam int STR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int USER_W     = 2;

    // ceil-free divide by six: x / 6 == (x * DIV6_MUL) >> DIV6_SHIFT for x < 2**17
    localparam int DIV6_MUL   = 43691;
    localparam int DIV6_SHIFT = 18;

    typedef enum logic [1:0] {
        MODE_TIGHT = 2'd0,
        MODE_LOOSE = 2'd1,
        MODE_PAIR  = 2'd2
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_PACK_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd3;

    localparam logic [GS_W-1:0] GSIZE_TIGHT = 4'd5;
    localparam logic [GS_W-1:0] GSIZE_LOOSE = 4'd8;
    localparam logic [GS_W-1:0] GSIZE_PAIR  = 4'd2;

    localparam logic [CNT_W-1:0] NPIX_TIGHT = 3'd4;
    localparam logic [CNT_W-1:0] NPIX_LOOSE = 3'd6;
    localparam logic [CNT_W-1:0] NPIX_PAIR  = 3'd1;

    // Effective frame geometry, derived from the configuration registers
    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] width;
        logic [HGT_W-1:0]  height;
        logic [STR_W-1:0]  stride;
    } t_geom;

    // Pixels completed by one byte; flags belong to the last pixel
    typedef struct packed {
        logic [NPIX_MAX-1:0][PIX_W-1:0] pix;
        logic [CNT_W-1:0]               cnt;
        logic                           row_end;
        logic                           frame_end;
    } t_bundle;

endpackage

### sv/raw10_bayer_unpacker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw10_bayer_unpacker_core
// Raw sensor byte stream to pixels: tight 5-byte/4-pixel, loose 8-byte/6-pixel
// and 16-bit little-endian pair packing, with row stride and width clipping.
//
//   channel   dir  handshake                     payload
//   s         in   i_s_tvalid / o_s_tready       i_s_tdata[7:0] data_byte
//   m         out  o_m_tvalid / i_m_tready       o_m_tdata[15:0] pixel_value,
//                                                o_m_tlast frame_end,
//                                                o_m_tuser row_end, run_last
//   cfg       in   i_cfg_valid / o_cfg_ready     i_cfg_index[2:0], i_cfg_data[14:0]
//
// One byte per cycle while the input is not held. A decoded group sits in a
// group register and leaves one pixel per cycle while the output is ready, so
// a byte closing a group waits while the previous group is still draining;
// pixels pass from it through the output register. Input is held after reset
// and after every config write while the registered stride and clamped
// geometry update. Synchronous active-low reset; output stalls never drop data.
// ----------------------------------------------------------------------------
module raw10_bayer_unpacker_core
    import rbu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,    // [7:0] data_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [PIX_W-1:0]      o_m_tdata,    // [15:0] pixel_value
    output logic                  o_m_tlast,
    output logic [USER_W-1:0]     o_m_tuser,    // [0] row_end, [1] run_last
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_geom   geom;
    logic    settle;
    logic    bnd_busy;
    logic    bnd_load;
    t_bundle bundle;

    rbu_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom),
        .o_settle    (settle)
    );

    rbu_unpack #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_unpack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_geom     (geom),
        .i_settle   (settle),
        .i_bnd_busy (bnd_busy),
        .o_bnd_load (bnd_load),
        .o_bundle   (bundle)
    );

    rbu_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (bnd_load),
        .i_bundle   (bundle),
        .o_busy     (bnd_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### sv/rbu_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_cfg
// Configuration registers and the registered effective geometry: clamped
// width and height, mode decode and the row stride in bytes.
// ----------------------------------------------------------------------------
module rbu_cfg
    import rbu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_geom                 o_geom,
    output logic                  o_settle
);

    localparam int LINE_MAX = (1 << LINE_W) - 1;
    localparam int HGT_MAX  = (1 << HGT_W) - 1;
    localparam int WMAX     = (MAX_WIDTH < LINE_MAX) ? MAX_WIDTH : LINE_MAX;
    localparam int HMAX     = (MAX_HEIGHT < HGT_MAX) ? MAX_HEIGHT : HGT_MAX;

    logic [1:0]        r_pack_mode;
    logic [LINE_W-1:0] r_line_width;
    logic [HGT_W-1:0]  r_frame_height;
    logic [RSTR_W-1:0] r_row_stride;
    logic              r_settle;
    t_geom             r_geom;
    t_geom             n_geom;

    logic              cfg_fire;
    t_mode             eff_mode;
    logic [LINE_W-1:0] eff_width;
    logic [HGT_W-1:0]  eff_height;
    logic [STR_W-1:0]  eff_stride;
    logic [14:0]       loose_x;
    logic [30:0]       loose_prod;
    logic [12:0]       loose_q;
    logic [16:0]       tight_x;
    logic [STR_W-1:0]  loose_stride;
    logic [STR_W-1:0]  tight_stride;
    logic [STR_W-1:0]  pair_stride;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_mode    <= MODE_TIGHT;
            r_line_width   <= LINE_W'(1);
            r_frame_height <= HGT_W'(1);
            r_row_stride   <= '0;
            r_settle       <= 1'b1;
        end else begin
            r_settle <= cfg_fire;
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_PACK_MODE:    r_pack_mode    <= i_cfg_data[1:0];
                    CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LINE_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HGT_W-1:0];
                    CFG_ROW_STRIDE:   r_row_stride   <= i_cfg_data[RSTR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (r_pack_mode)
            MODE_TIGHT: eff_mode = MODE_TIGHT;
            MODE_LOOSE: eff_mode = MODE_LOOSE;
            default:    eff_mode = MODE_PAIR;
        endcase

        if (r_line_width == '0) begin
            eff_width = LINE_W'(1);
        end else if (r_line_width > LINE_W'(WMAX)) begin
            eff_width = LINE_W'(WMAX);
        end else begin
            eff_width = r_line_width;
        end

        if (r_frame_height == '0) begin
            eff_height = HGT_W'(1);
        end else if (r_frame_height > HGT_W'(HMAX)) begin
            eff_height = HGT_W'(HMAX);
        end else begin
            eff_height = r_frame_height;
        end
    end

    // loose: ceil(w / 6) * 8
    assign loose_x      = {1'b0, eff_width} + 15'd5;
    assign loose_prod   = 31'(loose_x) * 31'(DIV6_MUL);
    assign loose_q      = 13'(loose_prod >> DIV6_SHIFT);
    assign loose_stride = {loose_q, 3'b000};

    // tight: ceil(5 * w / 32) * 8
    assign tight_x      = {1'b0, eff_width, 2'b00} + 17'(eff_width) + 17'd31;
    assign tight_stride = {1'b0, tight_x[16:5], 3'b000};

    assign pair_stride  = {1'b0, eff_width, 1'b0};

    always_comb begin
        if (eff_mode == MODE_LOOSE) begin
            eff_stride = loose_stride;
        end else if (r_row_stride != '0) begin
            eff_stride = {1'b0, r_row_stride};
        end else if (eff_mode == MODE_TIGHT) begin
            eff_stride = tight_stride;
        end else begin
            eff_stride = pair_stride;
        end
    end

    assign n_geom = '{mode: eff_mode, width: eff_width, height: eff_height,
                      stride: eff_stride};

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom   = r_geom;
    assign o_settle = r_settle;

    a_settle_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> r_settle)
        else $error("input not held for geometry update after config write");

    a_geom_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_settle |-> (r_geom.width != '0 && r_geom.height != '0 && r_geom.stride != '0))
        else $error("effective geometry holds a zero");

endmodule

### sv/rbu_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_unpack
// Byte intake: collects bytes into groups, decodes a finished group into
// pixels, clips at the line width and tracks row and frame position.
// ----------------------------------------------------------------------------
module rbu_unpack
    import rbu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  t_geom             i_geom,
    input  logic              i_settle,
    input  logic              i_bnd_busy,
    output logic              o_bnd_load,
    output t_bundle           o_bundle
);

    localparam int LINE_MAX = (1 << LINE_W) - 1;
    localparam int HGT_MAX  = (1 << HGT_W) - 1;
    localparam int WMAX     = (MAX_WIDTH < LINE_MAX) ? MAX_WIDTH : LINE_MAX;
    localparam int HMAX     = (MAX_HEIGHT < HGT_MAX) ? MAX_HEIGHT : HGT_MAX;
    localparam int COL_W    = $clog2(WMAX + 1);
    localparam int ROW_W    = (HMAX > 1) ? $clog2(HMAX) : 1;
    localparam int WC_W     = LINE_W + 1;
    localparam int RC_W     = HGT_W + 1;

    logic [GRP_BYTES-1:0][BYTE_W-1:0] r_group;
    logic [LANE_W-1:0]                r_big;
    logic [RSTR_W-1:0]                r_bir;
    logic [COL_W-1:0]                 r_col;
    logic [ROW_W-1:0]                 r_row;

    logic [GRP_BYTES-1:0][BYTE_W-1:0] n_group;
    logic [LANE_W-1:0]                n_big;
    logic [RSTR_W-1:0]                n_bir;
    logic [COL_W-1:0]                 n_col;
    logic [ROW_W-1:0]                 n_row;

    logic [GS_W-1:0]                  gsize;
    logic [CNT_W-1:0]                 npix;
    logic                             grp_wrap;
    logic [GS_W-1:0]                  big_eff;
    logic [LANE_W-1:0]                lane;
    logic                             complete;
    logic [GRP_BYTES*BYTE_W-1:0]      flat;
    logic [NPIX_MAX-1:0][PIX_W-1:0]   pix;
    logic [WC_W-1:0]                  col_x;
    logic [WC_W-1:0]                  w_x;
    logic [WC_W-1:0]                  rem;
    logic [WC_W-1:0]                  col_after;
    logic                             col_in;
    logic [CNT_W-1:0]                 emit_cnt;
    logic                             re_last;
    logic                             last_row;
    logic [STR_W-1:0]                 bir_inc;
    logic                             row_close;
    logic                             s_tready;
    logic                             fire;

    always_comb begin
        unique case (i_geom.mode)
            MODE_TIGHT: begin gsize = GSIZE_TIGHT; npix = NPIX_TIGHT; end
            MODE_LOOSE: begin gsize = GSIZE_LOOSE; npix = NPIX_LOOSE; end
            default:    begin gsize = GSIZE_PAIR;  npix = NPIX_PAIR;  end
        endcase
    end

    // a group count left over from another mode restarts the group
    assign grp_wrap = {1'b0, r_big} >= gsize;
    assign big_eff  = grp_wrap ? '0 : {1'b0, r_big};
    assign lane     = big_eff[LANE_W-1:0];
    assign complete = (big_eff + GS_W'(1)) == gsize;

    always_comb begin
        for (int k = 0; k < GRP_BYTES; k++) begin
            n_group[k] = (LANE_W'(k) == lane) ? i_s_tdata : r_group[k];
        end
    end

    assign flat = n_group;

    always_comb begin
        pix = '0;
        unique case (i_geom.mode)
            MODE_TIGHT: begin
                for (int i = 0; i < 4; i++) begin
                    pix[i] = PIX_W'({n_group[i], n_group[4][2*i +: 2]});
                end
            end
            MODE_LOOSE: begin
                for (int i = 0; i < NPIX_MAX; i++) begin
                    pix[i] = PIX_W'(flat[PIX10_W*i +: PIX10_W]);
                end
            end
            default: begin
                pix[0] = {n_group[1], n_group[0]};
            end
        endcase
    end

    // clip at the line width; only the last kept pixel can close the row
    assign col_x     = WC_W'(r_col);
    assign w_x       = WC_W'(i_geom.width);
    assign col_in    = col_x < w_x;
    assign rem       = w_x - col_x;
    assign emit_cnt  = !col_in ? '0 :
                       (rem < WC_W'(npix)) ? CNT_W'(rem) : npix;
    assign col_after = col_x + WC_W'(emit_cnt);
    assign re_last   = col_in && (col_after == w_x);
    assign last_row  = RC_W'(r_row) == (RC_W'(i_geom.height) - RC_W'(1));

    assign bir_inc   = {1'b0, r_bir} + STR_W'(1);
    assign row_close = bir_inc >= i_geom.stride;

    assign s_tready  = !i_settle && !(complete && i_bnd_busy);
    assign fire      = i_s_tvalid && s_tready;

    always_comb begin
        n_bir = r_bir;
        n_big = r_big;
        n_col = r_col;
        n_row = r_row;
        if (row_close) begin
            n_bir = '0;
            n_big = '0;
            n_col = '0;
            if ((RC_W'(r_row) + RC_W'(1)) >= RC_W'(i_geom.height)) begin
                n_row = '0;
            end else begin
                n_row = ROW_W'(RC_W'(r_row) + RC_W'(1));
            end
        end else begin
            n_bir = bir_inc[RSTR_W-1:0];
            n_big = complete ? '0 : LANE_W'(big_eff + GS_W'(1));
            if (complete) begin
                n_col = COL_W'(col_after);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big <= '0;
            r_bir <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (fire) begin
            r_big <= n_big;
            r_bir <= n_bir;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // lanes above the fill point are always rewritten before a decode
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_group <= n_group;
        end
    end

    assign o_s_tready         = s_tready;
    assign o_bnd_load         = fire && complete && (emit_cnt != '0);
    assign o_bundle.pix       = pix;
    assign o_bundle.cnt       = emit_cnt;
    assign o_bundle.row_end   = re_last;
    assign o_bundle.frame_end = re_last && last_row;

endmodule

### sv/rbu_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_serial
// Holds the pixels of one decoded group and sends them one per beat through
// the output register, flagging row end, frame end and the last of the group.
// ----------------------------------------------------------------------------
module rbu_serial
    import rbu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_bundle           i_bundle,
    output logic              o_busy,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [PIX_W-1:0]  o_m_tdata,
    output logic              o_m_tlast,
    output logic [USER_W-1:0] o_m_tuser
);

    t_bundle           r_bnd;
    logic              r_bnd_valid;
    logic [CNT_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_re;
    logic              r_out_fe;
    logic              r_out_last;

    logic              is_last;
    logic              move;

    assign is_last = r_idx == (r_bnd.cnt - CNT_W'(1));
    assign move    = r_bnd_valid && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_bnd_valid <= 1'b1;
                r_idx       <= '0;
            end else if (move) begin
                if (is_last) begin
                    r_bnd_valid <= 1'b0;
                end
                r_idx <= r_idx + CNT_W'(1);
            end

            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bnd <= i_bundle;
        end
        if (move) begin
            r_out_pix  <= r_bnd.pix[r_idx];
            r_out_last <= is_last;
            r_out_re   <= is_last && r_bnd.row_end;
            r_out_fe   <= is_last && r_bnd.frame_end;
        end
    end

    assign o_busy     = r_bnd_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tlast  = r_out_fe;
    assign o_m_tuser  = {r_out_last, r_out_re};

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bnd_valid |-> (r_bnd.cnt != '0 && r_idx < r_bnd.cnt))
        else $error("group index past pixel count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_bnd_valid)
        else $error("group loaded over pixels not yet sent");

    a_flag_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fe) |-> (r_out_re && r_out_last))
        else $error("frame end without row end on the last pixel of a group");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && is_last) |=> !r_bnd_valid || $past(i_load))
        else $error("group register not released after its last pixel");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for raw10_bayer_unpacker_core. Raw bytes go in on the
// slave stream and every accepted byte runs through a software unpacker that
// keeps its own copy of the geometry registers and position counters. The
// pixels it predicts are queued, and each pixel beat on the master stream is
// compared field by field against the oldest entry. Covers tight, loose and
// 16-bit pair packing, strides long and short, clamped geometry, row and
// frame flags, register writes between bursts, and random stalls on both
// sides, including a long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module testbench;
    import rbu_pkg::*;

    localparam int ITEMS         = 470;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;

    localparam logic [1:0]           MODE_CODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED     = 3'd4;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
        logic             run_last;
    } pix_beat_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [BYTE_W-1:0]     i_s_tdata   = '0;     // [7:0] data_byte
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [PIX_W-1:0]      o_m_tdata;            // [15:0] pixel_value
    logic                  o_m_tlast;
    logic [USER_W-1:0]     o_m_tuser;            // [0] row_end, [1] run_last
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    raw10_bayer_unpacker_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow registers and position counters of the unpacker
    logic [1:0]        reg_mode   = MODE_TIGHT;
    logic [LINE_W-1:0] reg_width  = 14'd1;
    logic [HGT_W-1:0]  reg_height = 14'd1;
    logic [RSTR_W-1:0] reg_stride = '0;
    logic [63:0]       grp        = '0;
    int                grp_fill   = 0;
    int                row_bytes  = 0;
    int                col        = 0;
    int                row_idx    = 0;

    pix_beat_t pending_pixels [$];

    int  errors   = 0;
    int  n_bytes  = 0;
    int  n_pix    = 0;
    int  n_rows   = 0;
    int  n_frames = 0;
    int  n_cfg    = 0;
    int  n_phases = 0;
    int  sink_hold = 0;
    bit  steady    = 1'b0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advance the shadow unpacker by one byte and queue the pixels it completes
    function automatic void unpack_byte(input logic [7:0] b);
        int          w, h, stride, gsize, npix;
        logic [1:0]  mode;
        logic [7:0]  lo;
        logic [15:0] pix [6];
        pix_beat_t   beats [$];
        pix_beat_t   bt;
        mode = (reg_mode == MODE_CODE_UNUSED) ? MODE_PAIR : reg_mode;
        w = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : int'(reg_width));
        h = (reg_height == 0) ? 1 : ((reg_height > MAX_H) ? MAX_H : int'(reg_height));
        if (mode == MODE_LOOSE)
            stride = ((w + 5) / 6) * 8;
        else if (reg_stride != 0)
            stride = reg_stride;
        else if (mode == MODE_TIGHT)
            stride = ((5 * w + 31) / 32) * 8;
        else
            stride = 2 * w;
        gsize = (mode == MODE_TIGHT) ? GSIZE_TIGHT :
                (mode == MODE_LOOSE) ? GSIZE_LOOSE : GSIZE_PAIR;
        npix = 0;

        // a mode change can leave the open group longer than the new size
        if (grp_fill >= gsize) begin
            grp_fill = 0;
            grp = '0;
        end
        grp[grp_fill*8 +: 8] = b;
        grp_fill++;

        if (grp_fill == gsize) begin
            if (mode == MODE_TIGHT) begin
                lo = grp[39:32];
                for (int i = 0; i < 4; i++)
                    pix[i] = {6'd0, grp[i*8 +: 8], lo[2*i +: 2]};
                npix = NPIX_TIGHT;
            end else if (mode == MODE_LOOSE) begin
                for (int i = 0; i < 6; i++)
                    pix[i] = {6'd0, grp[10*i +: 10]};
                npix = NPIX_LOOSE;
            end else begin
                pix[0] = grp[15:0];
                npix = NPIX_PAIR;
            end
            grp_fill = 0;
            grp = '0;
            for (int i = 0; i < npix; i++) begin
                // drop pixels past the row width
                if (col < w) begin
                    bt.pixel     = pix[i];
                    bt.row_end   = (col == w - 1);
                    bt.frame_end = bt.row_end && (row_idx == h - 1);
                    bt.run_last  = 1'b0;
                    beats.push_back(bt);
                    col++;
                end
            end
        end

        row_bytes++;
        if (row_bytes >= stride) begin
            row_bytes = 0;
            grp_fill  = 0;
            grp       = '0;
            col       = 0;
            row_idx   = (row_idx + 1 >= h) ? 0 : row_idx + 1;
        end
        row_bytes &= 32'h7fff;

        if (beats.size() > 0) beats[beats.size()-1].run_last = 1'b1;
        foreach (beats[i]) pending_pixels.push_back(beats[i]);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the beat
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = (steady || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(negedge i_clk); while (o_s_tready !== 1'b1);
        unpack_byte(b);
        n_bytes++;
        @(posedge i_clk);
    endtask

    // Stop sending and let every queued pixel drain, then allow the pipe to settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_PACK_MODE:    reg_mode   = val[1:0];
            CFG_LINE_WIDTH:   reg_width  = val[LINE_W-1:0];
            CFG_FRAME_HEIGHT: reg_height = val[HGT_W-1:0];
            CFG_ROW_STRIDE:   reg_stride = val[RSTR_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geom(input logic [1:0] mode, input logic [14:0] width,
                            input logic [14:0] height, input logic [14:0] stride);
        wait_idle();
        write_reg(CFG_PACK_MODE, {13'd0, mode});
        write_reg(CFG_LINE_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
        write_reg(CFG_ROW_STRIDE, stride);
        n_phases++;
    endtask

    // Reset values: tight, one pixel per row, derived stride of eight bytes
    task automatic test_reset_defaults();
        repeat (5) push_byte(8'hff);
        repeat (3) push_byte(8'h00);
        n_phases++;
    endtask

    task automatic test_loose_group();
        set_geom(MODE_LOOSE, 15'd6, 15'd2, 15'd0);
        push_byte(8'h01);
        push_byte(8'h80);
        push_byte(8'h55);
        push_byte(8'haa);
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte(8'h3c);
        push_byte(8'hc3);
    endtask

    // Mode code 3 falls back to pairs; height 0 acts as one row
    task automatic test_unused_mode();
        set_geom(MODE_CODE_UNUSED, 15'd1, 15'd0, 15'd0);
        push_byte(8'h34);
        push_byte(8'h12);
    endtask

    // Clamped width and height with a stride too short to finish a group
    task automatic test_short_stride();
        set_geom(MODE_TIGHT, 15'd16383, 15'd9000, 15'd3);
        write_reg(CFG_UNMAPPED + 3'($urandom_range(0, 3)), 15'h7fff);
        repeat (3) push_byte(8'($urandom));
    endtask

    // Shrink the frame below the current row so the count wraps
    task automatic test_height_wrap();
        set_geom(MODE_PAIR, 15'd1, 15'd5, 15'd0);
        repeat (4) push_byte(8'($urandom));
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, 15'd2);
        repeat (2) push_byte(8'($urandom));
    endtask

    task automatic test_extremes();
        set_geom(MODE_PAIR, 15'd8192, 15'd8192, 15'h7fff);
        repeat (20) push_byte(8'($urandom));
        set_geom(MODE_LOOSE, 15'd16383, 15'd16383, 15'd16384);
        repeat (16) push_byte(8'($urandom));
    endtask

    // Hold the output off long enough that the block must stall its input
    task automatic test_backpressure();
        set_geom(MODE_TIGHT, 15'd40, 15'd3, 15'd0);
        steady    = 1'b1;
        sink_hold = HOLD_CYCLES;
        repeat (60) push_byte(8'($urandom));
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        logic [1:0]  mode;
        logic [14:0] width, height, stride;
        int          nbytes, cut, phase;
        phase = 0;
        while (n_bytes < ITEMS) begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       width = 15'd0;
                1:       width = 15'($urandom_range(8193, 16383));
                2, 3:    width = 15'($urandom_range(25, 64));
                default: width = 15'($urandom_range(1, 24));
            endcase
            height = ($urandom_range(0, 7) == 0) ? 15'd0 : 15'($urandom_range(1, 4));
            stride = ($urandom_range(0, 1) == 0) ? 15'd0 : 15'($urandom_range(1, 96));
            set_geom(mode, width, height, stride);
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_UNMAPPED + 3'($urandom_range(0, 3)), 15'($urandom));
            steady = (phase % 4 == 1);
            nbytes = $urandom_range(20, 70);
            cut    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nbytes - 1) : 0;
            for (int k = 0; k < nbytes; k++) begin
                // sender pause: let every pending pixel come out mid-row
                if (k == cut && cut != 0) begin
                    i_s_tvalid <= 1'b0;
                    while (pending_pixels.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
                push_byte(8'($urandom));
            end
            steady = 1'b0;
            phase++;
        end
    endtask

    // Output ready: long hold-off when asked, otherwise random stalls
    initial begin : sink_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                i_m_tready <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    // Sample at the falling edge: a beat seen here is taken at the next rising edge
    initial begin : check_pixels
        pix_beat_t got, want;
        forever begin
            @(negedge i_clk);
            if ((o_m_tvalid && i_m_tready) === 1'b1) begin
                got.pixel     = o_m_tdata;
                got.row_end   = o_m_tuser[0];
                got.frame_end = o_m_tlast;
                got.run_last  = o_m_tuser[1];
                n_pix++;
                if (pending_pixels.size() == 0) begin
                    if (errors < 10)
                        $display("[%0t] unexpected beat: pix=%h row_end=%b frame_end=%b last=%b",
                                 $realtime, got.pixel, got.row_end, got.frame_end,
                                 got.run_last);
                    errors++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.row_end) n_rows++;
                    if (want.frame_end) n_frames++;
                    if (got !== want) begin
                        if (errors < 10)
                            $display("[%0t] mismatch: exp pix=%h re=%b fe=%b last=%b, got pix=%h re=%b fe=%b last=%b",
                                     $realtime, want.pixel, want.row_end, want.frame_end,
                                     want.run_last, got.pixel, got.row_end, got.frame_end,
                                     got.run_last);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(negedge i_clk);
            if ((i_s_tvalid && o_s_tready) === 1'b1 || (o_m_tvalid && i_m_tready) === 1'b1 ||
                (i_cfg_valid && o_cfg_ready) === 1'b1)
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles, %0d pixels pending",
                         idle, pending_pixels.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : run_tests
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_loose_group();
        test_unused_mode();
        test_short_stride();
        test_height_wrap();
        test_extremes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        if (pending_pixels.size() != 0) errors++;

        $display("covered %0d bytes over %0d register settings (%0d writes) in all pack modes",
                 n_bytes, n_phases, n_cfg);
        $display("checked %0d pixels, %0d row ends, %0d frame ends, %0d errors",
                 n_pix, n_rows, n_frames, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
